FILE: design/tach_pkg.sv
// Shared types and constants of the slot tachometer rpm filter.
`timescale 1ns / 1ps
package tach_pkg;

  localparam int unsigned EDGE_W     = 32;
  localparam int unsigned CONV_W     = 32;
  localparam int unsigned DIVIDEND_W = CONV_W + 8;
  localparam int unsigned RPM_OUT_W  = 24;
  localparam int unsigned WIN_W      = 8;
  localparam int unsigned ALPHA_W    = 9;
  localparam int unsigned TMO_W      = 16;
  localparam int unsigned APB_AW     = 4;
  localparam int unsigned APB_DW     = 32;

  localparam logic [CONV_W-1:0]  CONV_RESET    = 32'd24000000;
  localparam logic [WIN_W-1:0]   WINDOW_RESET  = 8'd8;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET   = 9'd77;
  localparam logic [TMO_W-1:0]   TIMEOUT_RESET = 16'd60;

  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [1:0] {
    REG_CONV,
    REG_WINDOW,
    REG_ALPHA,
    REG_TIMEOUT
  } reg_idx_e;

  typedef struct packed {
    logic              command;
    logic [EDGE_W-1:0] edge_time;
  } in_t;

  typedef struct packed {
    logic [RPM_OUT_W-1:0] rpm_q8;
    logic                 updated;
    logic                 stopped;
  } out_t;

  typedef struct packed {
    logic [CONV_W-1:0]  rpm_scale;
    logic [WIN_W-1:0]   captures_per_window;
    logic [ALPHA_W-1:0] alpha_q8;
    logic [TMO_W-1:0]   stop_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: design/slot_tachometer_rpm_filter_core.sv
// Top level of the slot tachometer rpm filter: sequencer, state and output register.
//
// channel   direction  handshake                   payload
// in        input      in_valid_i / in_ready_o     tach_pkg::in_t  (command, edge_time)
// out       output     out_valid_o / out_ready_i   tach_pkg::out_t (rpm_q8, updated, stopped)
// config    input      APB psel/penable/pwrite     paddr, pwdata, prdata
//
// A tick or a capture inside a window goes straight to the result step, which loads
// the output register. A capture that closes a window runs the divider, then capture,
// store, median and two multiply steps before the result step; a zero period skips
// the divider. in_ready_o is high only while idle.
// A result waits in the output register while the next request is accepted; a stalled
// receiver holds the sequencer in its last step. Reset clears state, loads defaults.
`timescale 1ns / 1ps
module slot_tachometer_rpm_filter_core #(
  parameter int unsigned TIMER_WIDTH = 32,
  parameter int unsigned RPM_WIDTH   = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  tach_pkg::in_t                in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output tach_pkg::out_t               out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tach_pkg::APB_AW-1:0]  paddr,
  input  logic [tach_pkg::APB_DW-1:0]  pwdata,
  output logic [tach_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);
  import tach_pkg::*;

  localparam logic [RPM_WIDTH-1:0] RPM_MAX = {RPM_WIDTH{1'b1}};
  localparam int unsigned PROD_W = RPM_WIDTH + ALPHA_W;
  localparam int unsigned ACC_W  = RPM_WIDTH + 10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_STORE,
    ST_MEDIAN,
    ST_MULA,
    ST_MULB,
    ST_RESULT
  } state_e;

  function automatic logic [RPM_WIDTH-1:0] mid_of_three(
    input logic [RPM_WIDTH-1:0] x,
    input logic [RPM_WIDTH-1:0] y,
    input logic [RPM_WIDTH-1:0] z
  );
    logic [RPM_WIDTH-1:0] m;
    if ((x <= y && y <= z) || (z <= y && y <= x)) begin
      m = y;
    end else if ((y <= x && x <= z) || (z <= x && x <= y)) begin
      m = x;
    end else begin
      m = z;
    end
    return m;
  endfunction

  cfg_t      cfg;
  div_stat_t div_stat;
  logic [DIVIDEND_W-1:0] quotient;
  logic                  div_start;

  state_e                 state_q, state_d;
  logic [TIMER_WIDTH-1:0] wend_q, wend_d;
  logic [6:0]             count_q, count_d;
  logic [RPM_WIDTH-1:0]   store_q [3];
  logic [RPM_WIDTH-1:0]   store_d [3];
  logic [1:0]             slot_q, slot_d;
  logic [RPM_WIDTH-1:0]   filt_q, filt_d;
  logic [TMO_W-1:0]       elapsed_q, elapsed_d;
  logic [RPM_WIDTH-1:0]   raw_q, raw_d;
  logic [RPM_WIDTH-1:0]   med_q, med_d;
  logic [PROD_W-1:0]      prod_q, prod_d;
  logic                   upd_q, upd_d;
  logic                   stop_q, stop_d;
  logic                   out_valid_q, out_valid_d;
  out_t                   out_q, out_d;

  logic [WIN_W-1:0]       win_eff;
  logic [WIN_W-1:0]       cnt_inc;
  logic [ALPHA_W-1:0]     alpha_eff;
  logic [TIMER_WIDTH-1:0] edge_t;
  logic [TIMER_WIDTH-1:0] period;
  logic [ALPHA_W-1:0]     mul_x;
  logic [RPM_WIDTH-1:0]   mul_y;
  logic [PROD_W-1:0]      prod;
  logic [ACC_W-1:0]       acc;
  logic [ACC_W-9:0]       acc_sh;
  logic [1:0]             slot_idx;
  logic [TMO_W-1:0]       elapsed_inc;
  logic                   in_acc;
  logic                   out_free;

  tach_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tach_div #(
    .DIVIDEND_W (DIVIDEND_W),
    .DIVISOR_W  (TIMER_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({cfg.rpm_scale, 8'd0}),
    .divisor_i  (period),
    .quotient_o (quotient),
    .stat_o     (div_stat)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign edge_t  = in_data_i.edge_time[TIMER_WIDTH-1:0];
  assign period  = edge_t - wend_q;
  assign cnt_inc = {1'b0, count_q} + WIN_W'(1);

  always_comb begin
    if (cfg.captures_per_window == '0) begin
      win_eff = WIN_W'(1);
    end else if (cfg.captures_per_window > WIN_W'(128)) begin
      win_eff = WIN_W'(128);
    end else begin
      win_eff = cfg.captures_per_window;
    end
    alpha_eff = (cfg.alpha_q8 > ALPHA_W'(256)) ? ALPHA_W'(256) : cfg.alpha_q8;
  end

  assign mul_x  = (state_q == ST_MULB) ? (ALPHA_W'(256) - alpha_eff) : alpha_eff;
  assign mul_y  = (state_q == ST_MULB) ? filt_q : med_q;
  assign prod   = PROD_W'(mul_x) * PROD_W'(mul_y);
  assign acc    = ACC_W'(prod_q) + ACC_W'(prod) + ACC_W'(128);
  assign acc_sh = acc[ACC_W-1:8];

  assign slot_idx    = (slot_q == 2'd3) ? 2'd0 : slot_q;
  assign elapsed_inc = (elapsed_q != {TMO_W{1'b1}}) ? elapsed_q + TMO_W'(1) : elapsed_q;

  always_comb begin
    state_d     = state_q;
    wend_d      = wend_q;
    count_d     = count_q;
    store_d     = store_q;
    slot_d      = slot_q;
    filt_d      = filt_q;
    elapsed_d   = elapsed_q;
    raw_d       = raw_q;
    med_d       = med_q;
    prod_d      = prod_q;
    upd_d       = upd_q;
    stop_d      = stop_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    div_start   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.command == CMD_TICK) begin
            upd_d     = 1'b0;
            stop_d    = 1'b0;
            elapsed_d = elapsed_inc;
            if (elapsed_inc > cfg.stop_timeout_ms) begin
              filt_d  = '0;
              store_d = '{default: '0};
              stop_d  = 1'b1;
            end
            state_d = ST_RESULT;
          end else begin
            stop_d = 1'b0;
            if (cnt_inc >= win_eff) begin
              count_d = '0;
              wend_d  = edge_t;
              upd_d   = 1'b1;
              if (period == '0) begin
                raw_d   = RPM_MAX;
                state_d = ST_STORE;
              end else begin
                div_start = 1'b1;
                state_d   = ST_DIVIDE;
              end
            end else begin
              count_d = cnt_inc[6:0];
              upd_d   = 1'b0;
              state_d = ST_RESULT;
            end
          end
        end
      end
      ST_DIVIDE: begin
        if (div_stat.done) begin
          raw_d   = ((quotient >> RPM_WIDTH) != '0) ? RPM_MAX : quotient[RPM_WIDTH-1:0];
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        store_d[slot_idx] = raw_q;
        slot_d  = (slot_idx == 2'd2) ? 2'd0 : slot_idx + 2'd1;
        state_d = ST_MEDIAN;
      end
      ST_MEDIAN: begin
        med_d   = mid_of_three(store_q[0], store_q[1], store_q[2]);
        state_d = ST_MULA;
      end
      ST_MULA: begin
        prod_d  = prod;
        state_d = ST_MULB;
      end
      ST_MULB: begin
        filt_d    = (acc_sh[ACC_W-9:RPM_WIDTH] != '0) ? RPM_MAX : acc_sh[RPM_WIDTH-1:0];
        elapsed_d = '0;
        state_d   = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          out_d.rpm_q8  = RPM_OUT_W'(filt_q);
          out_d.updated = upd_q;
          out_d.stopped = stop_q;
          out_valid_d   = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wend_q      <= '0;
      count_q     <= '0;
      store_q     <= '{default: '0};
      slot_q      <= '0;
      filt_q      <= '0;
      elapsed_q   <= '0;
      raw_q       <= '0;
      med_q       <= '0;
      prod_q      <= '0;
      upd_q       <= 1'b0;
      stop_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      wend_q      <= wend_d;
      count_q     <= count_d;
      store_q     <= store_d;
      slot_q      <= slot_d;
      filt_q      <= filt_d;
      elapsed_q   <= elapsed_d;
      raw_q       <= raw_d;
      med_q       <= med_d;
      prod_q      <= prod_d;
      upd_q       <= upd_d;
      stop_q      <= stop_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

endmodule

FILE: design/tach_regs.sv
// APB configuration registers of the slot tachometer rpm filter.
`timescale 1ns / 1ps
module tach_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tach_pkg::APB_AW-1:0]  paddr,
  input  logic [tach_pkg::APB_DW-1:0]  pwdata,
  output logic [tach_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  output tach_pkg::cfg_t               cfg_o
);
  import tach_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_CONV:    cfg_d.rpm_scale           = pwdata[CONV_W-1:0];
        REG_WINDOW:  cfg_d.captures_per_window = pwdata[WIN_W-1:0];
        REG_ALPHA:   cfg_d.alpha_q8            = pwdata[ALPHA_W-1:0];
        REG_TIMEOUT: cfg_d.stop_timeout_ms     = pwdata[TMO_W-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CONV:    prdata = APB_DW'(cfg_q.rpm_scale);
      REG_WINDOW:  prdata = APB_DW'(cfg_q.captures_per_window);
      REG_ALPHA:   prdata = APB_DW'(cfg_q.alpha_q8);
      REG_TIMEOUT: prdata = APB_DW'(cfg_q.stop_timeout_ms);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rpm_scale           <= CONV_RESET;
      cfg_q.captures_per_window <= WINDOW_RESET;
      cfg_q.alpha_q8            <= ALPHA_RESET;
      cfg_q.stop_timeout_ms     <= TIMEOUT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: design/tach_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module tach_div #(
  parameter int unsigned DIVIDEND_W = 40,
  parameter int unsigned DIVISOR_W  = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic [DIVIDEND_W-1:0] quotient_o,
  output tach_pkg::div_stat_t   stat_o
);
  import tach_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  dvs_q, dvs_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CNT_W'(DIVIDEND_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[DIVIDEND_W-2:0], ge};
      rem_d = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

FILE: design/tach_chk.sv
// Port-level assertions for the slot tachometer rpm filter, bound to the top level.
`timescale 1ns / 1ps
module tach_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input tach_pkg::in_t                in_data_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input tach_pkg::out_t               out_data_o,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [tach_pkg::APB_AW-1:0]  paddr,
  input logic [tach_pkg::APB_DW-1:0]  pwdata,
  input logic [tach_pkg::APB_DW-1:0]  prdata,
  input logic                         pready
);
  import tach_pkg::*;

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.updated && out_data_o.stopped))
    else $error("result flagged both updated and stopped");

  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.stopped |-> out_data_o.rpm_q8 == '0)
    else $error("stop result carries nonzero rpm");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable |-> pready)
    else $error("config access stalled");

endmodule

bind slot_tachometer_rpm_filter_core tach_chk u_tach_chk (.*);
